### sv/kfe_pkg.sv
// ----------------------------------------------------------------------------
// kfe_pkg: shared constants and types for the keyframe envelope evaluator
// Holds item kinds, curve shapes, arithmetic constants and the command and
// status groups that run between controller and datapath.
// ----------------------------------------------------------------------------
package kfe_pkg;

  localparam int POINT_DEPTH_DEF    = 1024;
  localparam int ENVELOPE_DEPTH_DEF = 64;

  localparam logic [1:0] KIND_WR_POINT = 2'd0;
  localparam logic [1:0] KIND_WR_ENV   = 2'd1;
  localparam logic [1:0] KIND_EVAL     = 2'd2;

  localparam logic [2:0] SHAPE_STEP   = 3'd0;
  localparam logic [2:0] SHAPE_SLOW   = 3'd2;
  localparam logic [2:0] SHAPE_FAST   = 3'd3;
  localparam logic [2:0] SHAPE_SMOOTH = 3'd4;

  // milliseconds to microseconds
  localparam logic [9:0]  MS_TO_US       = 10'd1000;
  // 64*pi/180 in Q30
  localparam logic [31:0] DEG_TO_RAD_Q30 = 32'd1199381129;
  localparam logic [16:0] FRAC_ONE       = 17'd65536;

  localparam int QUERY_W = 48;
  localparam int TIME_W  = 31;
  localparam int TUS_W   = 41;

  typedef struct packed {
    logic wr_pt;
    logic wr_env;
    logic eval_acc;
    logic env_cap;
    logic start_red;
    logic rd_last;
    logic cap_last;
    logic mod_step;
    logic rd_start;
    logic cap_p0;
    logic scan_adv;
    logic hit;
    logic frac_step;
    logic frac_first;
    logic use_last;
    logic sq;
    logic cu;
    logic shp;
    logic lerp;
    logic sum;
    logic rad;
    logic out_ok;
    logic out_err;
  } kfe_cmd_t;

  typedef struct packed {
    logic env_bad;
    logic len_zero;
    logic start_ge;
    logic n_one;
    logic seg_hit;
    logic seg_end;
  } kfe_status_t;

endpackage

### sv/kfe_datapath.sv
// ----------------------------------------------------------------------------
// kfe_datapath: storage and arithmetic of the envelope evaluator
// Point and envelope memories, a shared shift-subtract divider for the time
// wrap and the segment fraction, curve shaping, interpolation and radians.
// ----------------------------------------------------------------------------
module kfe_datapath #(
  parameter int POINT_DEPTH    = 1024,
  parameter int ENVELOPE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kfe_pkg::kfe_cmd_t   cmd,
  output kfe_pkg::kfe_status_t status,
  input  logic                cfg_wr_en,
  input  logic [6:0]          cfg_wr_data,
  input  logic [9:0]          in_slot_index,
  input  logic [30:0]         in_key_time_ms,
  input  logic [2:0]          in_curve_shape,
  input  logic signed [31:0]  in_key_x,
  input  logic signed [31:0]  in_key_y,
  input  logic signed [31:0]  in_key_degrees,
  input  logic [9:0]          in_first_point,
  input  logic [10:0]         in_point_count,
  input  logic [47:0]         in_query_time_us,
  output logic                out_valid,
  output logic signed [31:0]  out_pos_x,
  output logic signed [31:0]  out_pos_y,
  output logic signed [31:0]  out_angle_rad,
  output logic                out_status
);
  import kfe_pkg::*;

  localparam int PAW = (POINT_DEPTH > 1) ? $clog2(POINT_DEPTH) : 1;
  localparam int STW = (PAW > 10) ? PAW : 10;
  localparam int NW  = $clog2(POINT_DEPTH + 1);
  localparam int EAW = (ENVELOPE_DEPTH > 1) ? $clog2(ENVELOPE_DEPTH) : 1;
  localparam int ESW = (EAW > 10) ? EAW : 10;

  // memories
  logic [TIME_W-1:0] pt_time_mem  [POINT_DEPTH];
  logic [2:0]        pt_shape_mem [POINT_DEPTH];
  logic [95:0]       pt_val_mem   [POINT_DEPTH];
  logic [9:0]        env_start_mem[ENVELOPE_DEPTH];
  logic [10:0]       env_len_mem  [ENVELOPE_DEPTH];

  logic [TIME_W-1:0] rd_time_r;
  logic [2:0]        rd_shape_r;
  logic [95:0]       rd_val_r;
  logic [9:0]        env_start_rd_r;
  logic [10:0]       env_len_rd_r;

  logic [STW-1:0] slot_p;
  logic [ESW-1:0] slot_e;
  logic [PAW-1:0] pt_waddr;
  logic [EAW-1:0] env_addr;
  logic [PAW-1:0] pt_raddr;
  logic [PAW-1:0] ptr_base;
  logic [PAW-1:0] ptr_next;
  logic [PAW-1:0] last_addr;
  logic [31:0]    last_sum;

  logic [6:0]          count_r;
  logic                env_bad_r;
  logic [QUERY_W-1:0]  q_r;
  logic [STW-1:0]      start_r;
  logic [NW-1:0]       n_r;
  logic [PAW-1:0]      ptr_r;
  logic [NW-1:0]       seg_r;

  logic [TUS_W-1:0] div_r;
  logic [TUS_W-1:0] rem_r;
  logic [TUS_W-1:0] tw_r;
  logic             per_zero_r;
  logic             dz_r;
  logic [16:0]      a_r;

  logic [TUS_W-1:0] rd_tk;
  logic [TUS_W:0]   div_sh;
  logic             div_ge;
  logic [TUS_W:0]   div_diff;

  logic [TUS_W-1:0]   t0k_r;
  logic [2:0]         shape0_r;
  logic signed [31:0] p0_x_r, p0_y_r, p0_g_r;
  logic signed [31:0] p1_x_r, p1_y_r, p1_g_r;
  logic [95:0]        last_val_r;

  logic [16:0] a_eff;
  logic [16:0] s_val;
  logic [33:0] sq_r;
  logic [50:0] cu_r;
  logic [16:0] a_sh_r;
  logic [16:0] shaped;
  logic [52:0] smooth_num;

  logic signed [32:0] d_x, d_y, d_g;
  logic signed [17:0] a_s;
  logic signed [50:0] px_r, py_r, pg_r;
  logic signed [31:0] x_r, y_r, g_r;
  logic signed [63:0] rp_r;
  logic signed [63:0] rp_sh;
  logic signed [31:0] ang;

  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r, out_g_r;
  logic               out_st_r;

  assign slot_p   = STW'(in_slot_index);
  assign slot_e   = ESW'(in_slot_index);
  assign pt_waddr = slot_p[PAW-1:0];
  assign env_addr = slot_e[EAW-1:0];

  // next point index, wrapping at the table end
  assign ptr_base = cmd.cap_p0 ? PAW'(start_r) : ptr_r;
  assign ptr_next = (ptr_base == PAW'(POINT_DEPTH - 1)) ? '0 : ptr_base + 1'b1;

  always_comb begin
    last_sum = 32'(start_r) + 32'(n_r) - 32'd1;
    if (last_sum >= 32'(POINT_DEPTH)) begin
      last_sum = last_sum - 32'(POINT_DEPTH);
    end
    last_addr = PAW'(last_sum);
  end

  always_comb begin
    if (cmd.rd_last) begin
      pt_raddr = last_addr;
    end else if (cmd.rd_start) begin
      pt_raddr = PAW'(start_r);
    end else begin
      pt_raddr = ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_pt && (32'(in_slot_index) < 32'(POINT_DEPTH))) begin
      pt_time_mem[pt_waddr]  <= in_key_time_ms;
      pt_shape_mem[pt_waddr] <= in_curve_shape;
      pt_val_mem[pt_waddr]   <= {in_key_degrees, in_key_y, in_key_x};
    end
    rd_time_r  <= pt_time_mem[pt_raddr];
    rd_shape_r <= pt_shape_mem[pt_raddr];
    rd_val_r   <= pt_val_mem[pt_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_env && (32'(in_slot_index) < 32'(ENVELOPE_DEPTH))) begin
      env_start_mem[env_addr] <= in_first_point;
      env_len_mem[env_addr]   <= in_point_count;
    end
    env_start_rd_r <= env_start_mem[env_addr];
    env_len_rd_r   <= env_len_mem[env_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  // shared divider step: time wrap shifts in query bits, fraction shifts zeros except on its first step
  assign rd_tk = TUS_W'(rd_time_r) * TUS_W'(MS_TO_US);
  always_comb begin
    if (cmd.frac_first) begin
      div_sh = {1'b0, rem_r};
    end else if (cmd.mod_step) begin
      div_sh = {rem_r, q_r[QUERY_W-1]};
    end else begin
      div_sh = {rem_r, 1'b0};
    end
    div_ge   = div_sh >= {1'b0, div_r};
    div_diff = div_sh - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_acc) begin
      q_r       <= in_query_time_us;
      env_bad_r <= (32'(in_slot_index) >= 32'(count_r)) ||
                   (32'(in_slot_index) >= 32'(ENVELOPE_DEPTH));
    end
    if (cmd.env_cap) begin
      start_r <= STW'(env_start_rd_r);
      n_r     <= (32'(env_len_rd_r) > 32'(POINT_DEPTH)) ? NW'(POINT_DEPTH)
                                                        : NW'(env_len_rd_r);
    end
    if (cmd.start_red) begin
      start_r <= STW'(32'(start_r) - 32'(POINT_DEPTH));
    end
    if (cmd.cap_last) begin
      last_val_r <= rd_val_r;
      div_r      <= rd_tk;
      per_zero_r <= (rd_tk == '0);
      rem_r      <= '0;
    end
    if (cmd.mod_step) begin
      rem_r <= div_ge ? div_diff[TUS_W-1:0] : div_sh[TUS_W-1:0];
      q_r   <= {q_r[QUERY_W-2:0], 1'b0};
    end
    if (cmd.rd_start) begin
      tw_r  <= per_zero_r ? '0 : rem_r;
      ptr_r <= PAW'(start_r);
      seg_r <= '0;
    end
    if (cmd.cap_p0 || cmd.scan_adv) begin
      t0k_r    <= rd_tk;
      shape0_r <= rd_shape_r;
      p0_x_r   <= rd_val_r[31:0];
      p0_y_r   <= rd_val_r[63:32];
      p0_g_r   <= rd_val_r[95:64];
      ptr_r    <= ptr_next;
    end
    if (cmd.scan_adv) begin
      seg_r <= seg_r + 1'b1;
    end
    if (cmd.hit) begin
      p1_x_r <= rd_val_r[31:0];
      p1_y_r <= rd_val_r[63:32];
      p1_g_r <= rd_val_r[95:64];
      div_r  <= rd_tk - t0k_r;
      dz_r   <= (rd_tk == t0k_r);
      rem_r  <= tw_r - t0k_r;
      a_r    <= '0;
    end
    if (cmd.frac_step) begin
      rem_r <= div_ge ? div_diff[TUS_W-1:0] : div_sh[TUS_W-1:0];
      a_r   <= {a_r[15:0], div_ge};
    end
    if (cmd.use_last) begin
      p0_x_r <= last_val_r[31:0];
      p0_y_r <= last_val_r[63:32];
      p0_g_r <= last_val_r[95:64];
      p1_x_r <= last_val_r[31:0];
      p1_y_r <= last_val_r[63:32];
      p1_g_r <= last_val_r[95:64];
      a_sh_r <= '0;
    end
    if (cmd.sq) begin
      sq_r <= s_val * s_val;
    end
    if (cmd.cu) begin
      cu_r <= 51'(sq_r) * 51'(s_val);
    end
    if (cmd.shp) begin
      a_sh_r <= shaped;
    end
    if (cmd.lerp) begin
      px_r <= d_x * a_s;
      py_r <= d_y * a_s;
      pg_r <= d_g * a_s;
    end
    if (cmd.sum) begin
      x_r <= 32'(51'(p0_x_r) + (px_r >>> 16));
      y_r <= 32'(51'(p0_y_r) + (py_r >>> 16));
      g_r <= 32'(51'(p0_g_r) + (pg_r >>> 16));
    end
    if (cmd.rad) begin
      rp_r <= 64'(g_r) * 64'(signed'(DEG_TO_RAD_Q30));
    end
  end

  // a zero-length segment has fraction zero
  assign a_eff = dz_r ? '0 : a_r;
  assign s_val = (shape0_r == SHAPE_FAST) ? (FRAC_ONE - a_eff) : a_eff;
  assign smooth_num = 53'(3 * 53'(sq_r)) * 53'd65536 - 53'(2 * 53'(cu_r));

  always_comb begin
    case (shape0_r)
      SHAPE_STEP:   shaped = '0;
      SHAPE_SLOW:   shaped = cu_r[48:32];
      SHAPE_FAST:   shaped = FRAC_ONE - cu_r[48:32];
      SHAPE_SMOOTH: shaped = smooth_num[48:32];
      default:      shaped = a_eff;
    endcase
  end

  assign a_s = signed'({1'b0, a_sh_r});
  assign d_x = 33'(p1_x_r) - 33'(p0_x_r);
  assign d_y = 33'(p1_y_r) - 33'(p0_y_r);
  assign d_g = 33'(p1_g_r) - 33'(p0_g_r);

  // round half up, then saturate
  always_comb begin
    rp_sh = (rp_r + 64'sd536870912) >>> 30;
    if (rp_sh > 64'sd2147483647) begin
      ang = 32'sh7fffffff;
    end else if (rp_sh < -64'sd2147483648) begin
      ang = 32'sh80000000;
    end else begin
      ang = 32'(rp_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_ok || cmd.out_err;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ok) begin
      out_x_r  <= x_r;
      out_y_r  <= y_r;
      out_g_r  <= ang;
      out_st_r <= 1'b0;
    end else if (cmd.out_err) begin
      out_x_r  <= '0;
      out_y_r  <= '0;
      out_g_r  <= '0;
      out_st_r <= 1'b1;
    end
  end

  assign status.env_bad  = env_bad_r;
  assign status.len_zero = (env_len_rd_r == '0);
  assign status.start_ge = 32'(start_r) >= 32'(POINT_DEPTH);
  assign status.n_one    = (n_r == NW'(1));
  assign status.seg_hit  = (tw_r >= t0k_r) && (tw_r <= rd_tk);
  assign status.seg_end  = (seg_r == n_r - NW'(2));

  assign out_valid     = out_valid_r;
  assign out_pos_x     = out_x_r;
  assign out_pos_y     = out_y_r;
  assign out_angle_rad = out_g_r;
  assign out_status    = out_st_r;

endmodule

### sv/kfe_ctrl.sv
// ----------------------------------------------------------------------------
// kfe_ctrl: sequencer of the envelope evaluator
// Steps one evaluate transaction through lookup, time wrap, segment scan,
// fraction division, shaping, interpolation and output.
// ----------------------------------------------------------------------------
module kfe_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           in_kind,
  output logic                 busy,
  output kfe_pkg::kfe_cmd_t    cmd,
  input  kfe_pkg::kfe_status_t status
);
  import kfe_pkg::*;

  typedef enum logic [17:0] {
    ST_IDLE  = 18'b000000000000000001,
    ST_CHK   = 18'b000000000000000010,
    ST_RED   = 18'b000000000000000100,
    ST_LAST  = 18'b000000000000001000,
    ST_MOD   = 18'b000000000000010000,
    ST_S0RD  = 18'b000000000000100000,
    ST_S0CAP = 18'b000000000001000000,
    ST_SCAN  = 18'b000000000010000000,
    ST_FRAC  = 18'b000000000100000000,
    ST_SQ    = 18'b000000001000000000,
    ST_CU    = 18'b000000010000000000,
    ST_SHP   = 18'b000000100000000000,
    ST_LERP  = 18'b000001000000000000,
    ST_SUM   = 18'b000010000000000000,
    ST_RAD   = 18'b000100000000000000,
    ST_OUT   = 18'b001000000000000000,
    ST_ERR   = 18'b010000000000000000,
    ST_FALL  = 18'b100000000000000000
  } kfe_state_t;

  localparam logic [5:0] MOD_STEPS_M1  = 6'd47;
  localparam logic [5:0] FRAC_STEPS_M1 = 6'd16;

  kfe_state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       idle;

  assign idle = (state_r == ST_IDLE);
  assign busy = !idle;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.wr_pt    = (in_kind == KIND_WR_POINT);
          cmd.wr_env   = (in_kind == KIND_WR_ENV);
          cmd.eval_acc = (in_kind == KIND_EVAL);
          if (in_kind == KIND_EVAL) begin
            state_nxt = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        if (status.env_bad || status.len_zero) begin
          state_nxt = ST_ERR;
        end else begin
          cmd.env_cap = 1'b1;
          state_nxt   = ST_RED;
        end
      end
      ST_RED: begin
        // bring the first point index into the table range
        if (status.start_ge) begin
          cmd.start_red = 1'b1;
        end else begin
          cmd.rd_last = 1'b1;
          state_nxt   = ST_LAST;
        end
      end
      ST_LAST: begin
        cmd.cap_last = 1'b1;
        cnt_nxt      = MOD_STEPS_M1;
        state_nxt    = status.n_one ? ST_FALL : ST_MOD;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_S0RD;
        end
      end
      ST_S0RD: begin
        cmd.rd_start = 1'b1;
        state_nxt    = ST_S0CAP;
      end
      ST_S0CAP: begin
        cmd.cap_p0 = 1'b1;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.seg_hit) begin
          cmd.hit   = 1'b1;
          cnt_nxt   = FRAC_STEPS_M1;
          state_nxt = ST_FRAC;
        end else if (status.seg_end) begin
          state_nxt = ST_FALL;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      ST_FRAC: begin
        cmd.frac_step  = 1'b1;
        cmd.frac_first = (cnt_r == FRAC_STEPS_M1);
        cnt_nxt        = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = ST_CU;
      end
      ST_CU: begin
        cmd.cu    = 1'b1;
        state_nxt = ST_SHP;
      end
      ST_SHP: begin
        cmd.shp   = 1'b1;
        state_nxt = ST_LERP;
      end
      ST_FALL: begin
        cmd.use_last = 1'b1;
        state_nxt    = ST_LERP;
      end
      ST_LERP: begin
        cmd.lerp  = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_RAD;
      end
      ST_RAD: begin
        cmd.rad   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        cmd.out_ok = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_ERR: begin
        cmd.out_err = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### sv/keyframe_envelope_evaluator_top.sv
// ----------------------------------------------------------------------------
// keyframe_envelope_evaluator_top: keyframe envelope evaluator
// Point writes and envelope writes are taken while idle and do not raise
// busy. An evaluate transaction keeps busy high through one reduction step
// per table wrap of first_point, a bit-serial time wrap over the 48 query
// bits, a segment scan at one segment per cycle on the point memory port,
// a 17-bit fraction division and a short arithmetic tail. When no segment
// holds the time, division and shaping are skipped; a single-point envelope
// also skips the time wrap and the scan, and an invalid or empty one goes
// straight to the error result. Each result appears for one cycle with
// out_valid, in the cycle in which busy is low again; the receiver cannot
// stall it, so it must take every result as it comes.
// ----------------------------------------------------------------------------
module keyframe_envelope_evaluator_top #(
  parameter int POINT_DEPTH    = kfe_pkg::POINT_DEPTH_DEF,
  parameter int ENVELOPE_DEPTH = kfe_pkg::ENVELOPE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_kind,
  input  logic [9:0]         in_slot_index,
  input  logic [30:0]        in_key_time_ms,
  input  logic [2:0]         in_curve_shape,
  input  logic signed [31:0] in_key_x,
  input  logic signed [31:0] in_key_y,
  input  logic signed [31:0] in_key_degrees,
  input  logic [9:0]         in_first_point,
  input  logic [10:0]        in_point_count,
  input  logic [47:0]        in_query_time_us,
  output logic               out_valid,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_angle_rad,
  output logic               out_status,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data
);
  import kfe_pkg::*;

  kfe_cmd_t    cmd;
  kfe_status_t status;

  kfe_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .busy    (busy),
    .cmd     (cmd),
    .status  (status)
  );

  kfe_datapath #(
    .POINT_DEPTH    (POINT_DEPTH),
    .ENVELOPE_DEPTH (ENVELOPE_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_slot_index    (in_slot_index),
    .in_key_time_ms   (in_key_time_ms),
    .in_curve_shape   (in_curve_shape),
    .in_key_x         (in_key_x),
    .in_key_y         (in_key_y),
    .in_key_degrees   (in_key_degrees),
    .in_first_point   (in_first_point),
    .in_point_count   (in_point_count),
    .in_query_time_us (in_query_time_us),
    .out_valid        (out_valid),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_angle_rad    (out_angle_rad),
    .out_status       (out_status)
  );

endmodule
